// ----- sv/raster_neighbour_cell_finder_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the raster neighbour cell finder
// Shared helpers, sampled on the rising clock edge and off during reset.
// ----------------------------------------------------------------------------
`ifndef RASTER_NEIGHBOUR_CELL_FINDER_TOP_DEFINES_SVH
`define RASTER_NEIGHBOUR_CELL_FINDER_TOP_DEFINES_SVH

// same-cycle implication
`define RNC_ASSERT_IMPL(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("rnc same-cycle check failed");

// next-cycle implication
`define RNC_ASSERT_NEXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("rnc next-cycle check failed");

`endif

// ----- sv/rnc_pkg.sv -----
// ----------------------------------------------------------------------------
// rnc_pkg
// Widths, register indexes and shared types of the raster neighbour finder.
// ----------------------------------------------------------------------------
package rnc_pkg;

   localparam int CELL_W     = 25;
   localparam int DIM_W      = 13;
   localparam int MAX_ROWS   = 4096;
   localparam int MAX_COLS   = 4096;
   // row index below MAX_ROWS
   localparam int QUO_W      = $clog2(MAX_ROWS);
   localparam int SEL_W      = $clog2(QUO_W);
   localparam int NUM_NBR    = 8;
   localparam int MOVE_W     = 8 * NUM_NBR;
   localparam int CSR_DATA_W = MOVE_W;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] REG_ROWS  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_COLS  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_MOVES = CSR_IDX_W'(2);

   // item moving down the divider chain; rem holds remainder plus one
   typedef struct packed {
      logic [CELL_W-1:0] cell_id;
      logic [CELL_W-1:0] rem;
      logic [QUO_W-1:0]  quo;
   } div_item_type;

   typedef struct packed {
      logic [DIM_W-1:0]  rows;
      logic [DIM_W-1:0]  cols;
      logic [CELL_W-1:0] total;
      logic [MOVE_W-1:0] moves;
   } grid_cfg_type;

   typedef struct packed {
      logic [NUM_NBR-1:0][CELL_W-1:0] nbr;
      logic [NUM_NBR-1:0]             mask;
      logic                           bad;
   } rsp_item_type;

   function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, int unsigned max_v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_W'(max_v)) begin
         r = DIM_W'(max_v);
      end
      return r;
   endfunction

endpackage

// ----- sv/raster_neighbour_cell_finder_top.sv -----
// ----------------------------------------------------------------------------
// raster_neighbour_cell_finder_top
// Eight-neighbour lookup for 1-based row-major raster cell ids.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one cell id per item (valid/ready). rsp_* returns, per item,
//   eight neighbour ids, a valid mask and a bad-cell flag (valid/ready).
//   csr_we/csr_index/csr_wdata write grid_rows (0), grid_cols (1) and the
//   move table (2); write only while no item is in flight.
// Pipeline: the item passes twelve division cells, each settling one row bit
//   of cell / cols, and lands in the neighbour stage that adds the moves and
//   holds the result.
// Throughput: one item per cycle; each cell takes a new item whenever it is
//   empty or its content moves on, so bubbles collapse under a stall.
// Stall: with rsp_ready low, items pile up in the cells; req_ready drops
//   once all thirteen stages hold an item.
// Reset: empties the chain, holds req_ready low and sets rows = cols = 1,
//   move table = 0.
// ----------------------------------------------------------------------------
`include "raster_neighbour_cell_finder_top_defines.svh"

module raster_neighbour_cell_finder_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [rnc_pkg::CELL_W-1:0]     req_cell_id,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [rnc_pkg::CELL_W-1:0]     rsp_neighbour_0,
   output logic [rnc_pkg::CELL_W-1:0]     rsp_neighbour_1,
   output logic [rnc_pkg::CELL_W-1:0]     rsp_neighbour_2,
   output logic [rnc_pkg::CELL_W-1:0]     rsp_neighbour_3,
   output logic [rnc_pkg::CELL_W-1:0]     rsp_neighbour_4,
   output logic [rnc_pkg::CELL_W-1:0]     rsp_neighbour_5,
   output logic [rnc_pkg::CELL_W-1:0]     rsp_neighbour_6,
   output logic [rnc_pkg::CELL_W-1:0]     rsp_neighbour_7,
   output logic [rnc_pkg::NUM_NBR-1:0]    rsp_valid_mask,
   output logic                           rsp_bad_cell,
   input  logic                           csr_we,
   input  logic [rnc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rnc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rnc_pkg::*;

   logic [DIM_W-1:0]  rows_ff;
   logic [DIM_W-1:0]  cols_ff;
   logic [MOVE_W-1:0] moves_ff;
   logic [CELL_W-1:0] total_ff;
   logic [CELL_W-1:0] total_in;
   grid_cfg_type      cfg;
   rsp_item_type      rsp_item;

   logic         chain_valid [QUO_W+1];
   logic         chain_ready [QUO_W+1];
   div_item_type chain_item  [QUO_W+1];

   // ---- configuration ----
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= DIM_W'(1);
         cols_ff  <= DIM_W'(1);
         moves_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_ROWS:  rows_ff  <= clamp_dim(csr_wdata[DIM_W-1:0], MAX_ROWS);
            REG_COLS:  cols_ff  <= clamp_dim(csr_wdata[DIM_W-1:0], MAX_COLS);
            REG_MOVES: moves_ff <= csr_wdata[MOVE_W-1:0];
            default:   ;
         endcase
      end
   end

   // total is registered from the rows and cols registers, long before any item needs it
   assign total_in = CELL_W'(rows_ff) * CELL_W'(cols_ff);

   always_ff @(posedge clock) begin
      total_ff <= total_in;
   end

   assign cfg = '{rows: rows_ff, cols: cols_ff, total: total_ff, moves: moves_ff};

   // ---- division chain ----
   assign chain_valid[0] = req_valid;
   assign req_ready      = chain_ready[0] && !reset;
   assign chain_item[0]  = '{cell_id: req_cell_id, rem: req_cell_id, quo: '0};

   for (genvar i = 0; i < QUO_W; i++) begin : g_div
      rnc_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .bit_sel   (SEL_W'(QUO_W - 1 - i)),
         .cols      (cols_ff),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_item   (chain_item[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_item  (chain_item[i+1])
      );
   end

   rnc_nbr_stage u_nbr (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (chain_valid[QUO_W]),
      .in_ready  (chain_ready[QUO_W]),
      .in_item   (chain_item[QUO_W]),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_item  (rsp_item)
   );

   assign rsp_neighbour_0 = rsp_item.nbr[0];
   assign rsp_neighbour_1 = rsp_item.nbr[1];
   assign rsp_neighbour_2 = rsp_item.nbr[2];
   assign rsp_neighbour_3 = rsp_item.nbr[3];
   assign rsp_neighbour_4 = rsp_item.nbr[4];
   assign rsp_neighbour_5 = rsp_item.nbr[5];
   assign rsp_neighbour_6 = rsp_item.nbr[6];
   assign rsp_neighbour_7 = rsp_item.nbr[7];
   assign rsp_valid_mask  = rsp_item.mask;
   assign rsp_bad_cell    = rsp_item.bad;

   // ---- checks ----
   `RNC_ASSERT_IMPL(a_bad_no_mask, rsp_valid && rsp_bad_cell, rsp_valid_mask == '0)
   `RNC_ASSERT_IMPL(a_masked_zero, rsp_valid && !rsp_valid_mask[0], rsp_neighbour_0 == '0)
   `RNC_ASSERT_IMPL(a_valid_nonzero, rsp_valid && rsp_valid_mask[0], rsp_neighbour_0 != '0)
   `RNC_ASSERT_IMPL(a_rows_clamped, 1'b1, rows_ff != '0 && rows_ff <= DIM_W'(MAX_ROWS))
   `RNC_ASSERT_IMPL(a_cols_clamped, 1'b1, cols_ff != '0 && cols_ff <= DIM_W'(MAX_COLS))
   `RNC_ASSERT_NEXT(a_accept_fills, req_valid && req_ready, chain_valid[1])

endmodule

// ----- sv/rnc_div_cell.sv -----
// ----------------------------------------------------------------------------
// rnc_div_cell
// One restoring-division step: settles one quotient bit of cell / cols.
// ----------------------------------------------------------------------------
module rnc_div_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [rnc_pkg::SEL_W-1:0] bit_sel,
   input  logic [rnc_pkg::DIM_W-1:0] cols,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  rnc_pkg::div_item_type     in_item,
   output logic                      out_valid,
   input  logic                      out_ready,
   output rnc_pkg::div_item_type     out_item
);
   import rnc_pkg::*;

   logic              valid_ff;
   div_item_type      item_ff;
   div_item_type      item_in;
   logic [CELL_W-1:0] trial;

   assign trial = CELL_W'(cols) << bit_sel;

   // rem carries remainder + 1, so strict compare stands for >=
   always_comb begin
      item_in = in_item;
      if (in_item.rem > trial) begin
         item_in.rem = in_item.rem - trial;
         item_in.quo = in_item.quo | (QUO_W'(1) << bit_sel);
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

endmodule

// ----- sv/rnc_nbr_stage.sv -----
// ----------------------------------------------------------------------------
// rnc_nbr_stage
// Applies the eight moves to (row, col), range checks, and holds the result.
// ----------------------------------------------------------------------------
module rnc_nbr_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  rnc_pkg::grid_cfg_type cfg,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  rnc_pkg::div_item_type in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output rnc_pkg::rsp_item_type out_item
);
   import rnc_pkg::*;

   logic                valid_ff;
   rsp_item_type        item_ff;
   rsp_item_type        item_in;
   logic                bad;
   logic [DIM_W-1:0]    col;
   logic signed [3:0]   dr    [NUM_NBR];
   logic signed [3:0]   dc    [NUM_NBR];
   logic signed [13:0]  rq    [NUM_NBR];
   logic signed [14:0]  cc    [NUM_NBR];
   logic signed [17:0]  drc   [NUM_NBR];
   logic signed [26:0]  id_s  [NUM_NBR];
   logic                ok    [NUM_NBR];

   assign bad = (in_item.cell_id == '0) || (in_item.cell_id > cfg.total);
   // remainder + 1 is the 1-based column
   assign col = in_item.rem[DIM_W-1:0];

   always_comb begin
      item_in.bad = bad;
      for (int n = 0; n < NUM_NBR; n++) begin
         dr[n]   = $signed(cfg.moves[8*n+4 +: 4]);
         dc[n]   = $signed(cfg.moves[8*n +: 4]);
         rq[n]   = $signed({2'b00, in_item.quo}) + 14'(dr[n]);
         cc[n]   = $signed({2'b00, col}) + 15'(dc[n]);
         ok[n]   = (rq[n] >= 14'sd0) && (rq[n] < $signed({1'b0, cfg.rows}))
                   && (cc[n] >= 15'sd1) && (cc[n] <= $signed({2'b00, cfg.cols}));
         drc[n]  = 18'(dr[n]) * $signed({5'b00000, cfg.cols});
         // neighbour id = cell + dr * cols + dc
         id_s[n] = $signed({2'b00, in_item.cell_id}) + 27'(drc[n]) + 27'(dc[n]);
         item_in.mask[n] = !bad && ok[n];
         item_in.nbr[n]  = (!bad && ok[n]) ? id_s[n][CELL_W-1:0] : '0;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

endmodule

// ----- tb/raster_neighbour_cell_finder_top_tb.sv -----
// ----------------------------------------------------------------------------
// raster_neighbour_cell_finder_top_tb
// Streams cell ids through the neighbour finder under several grid and move
// settings, with random gaps on both handshakes. Each item is predicted from a
// mirror of the grid registers and compared field by field with its result.
// ----------------------------------------------------------------------------
module raster_neighbour_cell_finder_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rnc_pkg::*;

   // index 3 has no register behind it
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = CSR_IDX_W'(3);
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int RANDOM_PHASES = 15;
   localparam int PHASE_ITEMS   = 50;
   localparam int MAX_PRINTS    = 40;

   // entry 0 in the low byte; each byte is {row offset, column offset}
   localparam logic [MOVE_W-1:0] KING_MOVES =
      {8'h11, 8'h10, 8'h1F, 8'h01, 8'h0F, 8'hF1, 8'hF0, 8'hFF};
   localparam logic [MOVE_W-1:0] FAR_MOVES =
      {8'h70, 8'h08, 8'h07, 8'h00, 8'h78, 8'h87, 8'h77, 8'h88};

   class neighbour_scoreboard;
      logic [DIM_W-1:0]  rows_reg;
      logic [DIM_W-1:0]  cols_reg;
      logic [MOVE_W-1:0] moves_reg;
      rsp_item_type      expected_q[$];
      int                errors;

      function new();
         rows_reg  = DIM_W'(1);
         cols_reg  = DIM_W'(1);
         moves_reg = '0;
         errors    = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_ROWS:  rows_reg  = data[DIM_W-1:0];
            REG_COLS:  cols_reg  = data[DIM_W-1:0];
            REG_MOVES: moves_reg = data;
            default: ;
         endcase
      endfunction

      function int unsigned eff_dim(logic [DIM_W-1:0] v, int unsigned cap);
         if (v == '0) return 1;
         if (v > cap) return cap;
         return v;
      endfunction

      function longint grid_cells();
         return longint'(eff_dim(rows_reg, MAX_ROWS)) * longint'(eff_dim(cols_reg, MAX_COLS));
      endfunction

      function rsp_item_type neighbours_of(logic [CELL_W-1:0] cell_id);
         rsp_item_type     r;
         longint           c, ncols, nrows, row, col, nr, nc;
         logic [7:0]       mv;
         logic signed [3:0] dr, dc;
         int               n;
         r     = '0;
         nrows = eff_dim(rows_reg, MAX_ROWS);
         ncols = eff_dim(cols_reg, MAX_COLS);
         c     = cell_id;
         if (c == 0 || c > nrows * ncols) begin
            r.bad = 1'b1;
            return r;
         end
         row = (c + ncols - 1) / ncols;
         col = c - (row - 1) * ncols;
         for (n = 0; n < NUM_NBR; n++) begin
            mv = moves_reg[8*n +: 8];
            dr = mv[7:4];
            dc = mv[3:0];
            nr = row + dr;
            nc = col + dc;
            if (nr >= 1 && nr <= nrows && nc >= 1 && nc <= ncols) begin
               r.nbr[n]  = CELL_W'((nr - 1) * ncols + nc);
               r.mask[n] = 1'b1;
            end
         end
         return r;
      endfunction

      function void note_cell(logic [CELL_W-1:0] cell_id);
         expected_q.push_back(neighbours_of(cell_id));
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      task report_mismatch(string what, logic [CELL_W-1:0] got, logic [CELL_W-1:0] want);
         errors++;
         if (errors <= MAX_PRINTS)
            $display("[%0t] mismatch %s: got %0h want %0h", $realtime, what, got, want);
      endtask

      task check_result(rsp_item_type got);
         rsp_item_type want;
         int           n;
         if (expected_q.size() == 0) begin
            report_mismatch("result with no item pending", '0, '0);
            return;
         end
         want = expected_q.pop_front();
         for (n = 0; n < NUM_NBR; n++) begin
            if (got.nbr[n] !== want.nbr[n])
               report_mismatch($sformatf("neighbour_%0d", n), got.nbr[n], want.nbr[n]);
         end
         if (got.mask !== want.mask)
            report_mismatch("valid_mask", CELL_W'(got.mask), CELL_W'(want.mask));
         if (got.bad !== want.bad)
            report_mismatch("bad_cell", CELL_W'(got.bad), CELL_W'(want.bad));
      endtask
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [CELL_W-1:0]      req_cell_id = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [CELL_W-1:0]      rsp_neighbour_0, rsp_neighbour_1, rsp_neighbour_2, rsp_neighbour_3;
   logic [CELL_W-1:0]      rsp_neighbour_4, rsp_neighbour_5, rsp_neighbour_6, rsp_neighbour_7;
   logic [NUM_NBR-1:0]     rsp_valid_mask;
   logic                   rsp_bad_cell;
   logic                   csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   rsp_item_type           seen;
   neighbour_scoreboard    sb = new();
   bit                     src_calm = 1'b0;
   bit                     sink_calm = 1'b0;
   int                     sink_hold = 0;
   int unsigned            cycles = 0;

   raster_neighbour_cell_finder_top DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cell_id     (req_cell_id),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_neighbour_0 (rsp_neighbour_0),
      .rsp_neighbour_1 (rsp_neighbour_1),
      .rsp_neighbour_2 (rsp_neighbour_2),
      .rsp_neighbour_3 (rsp_neighbour_3),
      .rsp_neighbour_4 (rsp_neighbour_4),
      .rsp_neighbour_5 (rsp_neighbour_5),
      .rsp_neighbour_6 (rsp_neighbour_6),
      .rsp_neighbour_7 (rsp_neighbour_7),
      .rsp_valid_mask  (rsp_valid_mask),
      .rsp_bad_cell    (rsp_bad_cell),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   assign seen = {rsp_neighbour_7, rsp_neighbour_6, rsp_neighbour_5, rsp_neighbour_4,
                  rsp_neighbour_3, rsp_neighbour_2, rsp_neighbour_1, rsp_neighbour_0,
                  rsp_valid_mask, rsp_bad_cell};

   initial begin
      forever #5 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 8);
      return $urandom_range(20, 60);
   endfunction

   always @(posedge clock) begin
      if (sink_hold > 0) begin
         sink_hold--;
         rsp_ready <= 1'b0;
      end else if (sink_calm) begin
         rsp_ready <= 1'b1;
      end else begin
         sink_hold = idle_len();
         rsp_ready <= (sink_hold == 0);
         if (sink_hold > 0) sink_hold--;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(seen);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("raster_neighbour_cell_finder_top_tb NOT OK");
         $finish;
      end
   end

   task automatic send_cell(logic [CELL_W-1:0] cell_id);
      int gap;
      gap = src_calm ? 0 : idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_cell_id <= cell_id;
      do @(posedge clock); while (!req_ready);
      sb.note_cell(cell_id);
   endtask

   // drop valid and hold off until every result is back
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic put_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   task automatic program_grid(logic [CSR_DATA_W-1:0] rows_word,
                               logic [CSR_DATA_W-1:0] cols_word,
                               logic [MOVE_W-1:0] moves, bit poke_spare);
      put_reg(REG_ROWS, rows_word);
      put_reg(REG_COLS, cols_word);
      put_reg(REG_MOVES, moves);
      if (poke_spare) put_reg(REG_SPARE, {$urandom, $urandom});
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [DIM_W-1:0] pick_dim();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return DIM_W'($urandom_range(1, 12));
      if (r < 80) return DIM_W'($urandom_range(13, 100));
      if (r < 88) return DIM_W'($urandom_range(4090, 4096));
      if (r < 92) return '0;
      return DIM_W'($urandom_range(4097, 8191));
   endfunction

   function automatic logic [MOVE_W-1:0] pick_moves();
      logic [MOVE_W-1:0] m;
      int                n;
      case ($urandom_range(0, 3))
         0: m = KING_MOVES;
         3: begin
            // offsets of -1..1 keep most neighbours inside small grids
            for (n = 0; n < NUM_NBR; n++)
               m[8*n +: 8] = {4'($urandom_range(0, 2) - 1), 4'($urandom_range(0, 2) - 1)};
         end
         default: m = {$urandom, $urandom};
      endcase
      return m;
   endfunction

   function automatic logic [CELL_W-1:0] pick_cell();
      longint total, ncols;
      int     r;
      total = sb.grid_cells();
      ncols = sb.eff_dim(sb.cols_reg, MAX_COLS);
      r     = $urandom_range(0, 99);
      if (r < 70) return CELL_W'($urandom_range(1, int'(total)));
      if (r < 80) begin
         case ($urandom_range(0, 3))
            0: return CELL_W'(1);
            1: return CELL_W'(total);
            2: return CELL_W'(ncols);
            default: return CELL_W'(total - ncols + 1);
         endcase
      end
      if (r < 88) return $urandom_range(0, 1) ? CELL_W'(total + 1) : '0;
      return CELL_W'($urandom);
   endfunction

   task automatic random_phase();
      logic [CSR_DATA_W-1:0] rows_word, cols_word;
      int                    i;
      rows_word = {$urandom, $urandom};
      cols_word = {$urandom, $urandom};
      rows_word[DIM_W-1:0] = pick_dim();
      cols_word[DIM_W-1:0] = pick_dim();
      program_grid(rows_word, cols_word, pick_moves(), $urandom_range(0, 3) == 0);
      src_calm  = ($urandom_range(0, 3) == 0);
      sink_calm = ($urandom_range(0, 3) == 0);
      for (i = 0; i < PHASE_ITEMS; i++) send_cell(pick_cell());
      settle();
   endtask

   initial begin
      int p;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset grid is one cell with all moves at zero
      send_cell(CELL_W'(0));
      send_cell(CELL_W'(1));
      send_cell(CELL_W'(2));
      send_cell('1);
      settle();

      // 4 x 5 grid, corners, an inner cell and out of range ids
      program_grid(64'd4, 64'd5, KING_MOVES, 1'b0);
      send_cell(CELL_W'(1));
      send_cell(CELL_W'(5));
      send_cell(CELL_W'(16));
      send_cell(CELL_W'(20));
      send_cell(CELL_W'(7));
      send_cell(CELL_W'(21));
      send_cell(CELL_W'(0));
      send_cell(CELL_W'(25'h1000000));
      settle();

      // zero rows clamp to one, oversized cols clamp to the maximum
      program_grid(64'hFFFF_FFFF_FFFF_E000, 64'h1FFF, FAR_MOVES, 1'b1);
      send_cell(CELL_W'(1));
      send_cell(CELL_W'(9));
      send_cell(CELL_W'(4096));
      send_cell(CELL_W'(4097));
      settle();

      // largest grid
      program_grid(64'h1FFF, 64'd4096, FAR_MOVES, 1'b0);
      send_cell(CELL_W'(1));
      send_cell(CELL_W'(4096));
      send_cell(CELL_W'(4096 * 2047 + 2048));
      send_cell(CELL_W'(16777216 - 4095));
      send_cell(CELL_W'(16777216));
      send_cell(CELL_W'(16777217));
      settle();

      for (p = 0; p < RANDOM_PHASES; p++) random_phase();

      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("raster_neighbour_cell_finder_top_tb OK");
      end else begin
         $display("raster_neighbour_cell_finder_top_tb NOT OK");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+sv
sv/rnc_pkg.sv
sv/rnc_div_cell.sv
sv/rnc_nbr_stage.sv
sv/raster_neighbour_cell_finder_top.sv
tb/raster_neighbour_cell_finder_top_tb.sv
